[hdl/pire_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pire_pkg
// Shared types, constants and the rate table for the peak interval rate
// estimator.
// ----------------------------------------------------------------------------
package pire_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int SPAN_W    = 14;
    localparam int RATE_W    = 6;
    localparam int SPACING_W = 8;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DEPTH_MAX     = 64;
    localparam int GAP_W         = $clog2(DEPTH_MAX);

    localparam logic [SPACING_W-1:0] SPACING_RESET = 8'd20;
    localparam logic [RATE_W-1:0]    RATE_SAT      = 6'd63;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef struct packed {
        logic                command;
        logic [SAMPLE_W-1:0] sample;
    } cmd_t;

    typedef struct packed {
        logic [SPAN_W-1:0] span;
        logic [RATE_W-1:0] rate;
        logic              last_result;
    } result_t;

    // one match handed from the scan logic to the rate unit
    typedef struct packed {
        logic             vld;
        logic [GAP_W-1:0] gap;
        logic             last;
    } rate_req_t;

    // 60 / span, truncated; zero span saturates
    function automatic logic [RATE_W-1:0] rate_of(input logic [SPAN_W-1:0] s);
        logic [RATE_W-1:0] r;
        case (s) inside
            14'd0:            r = RATE_SAT;
            14'd1:            r = 6'd60;
            14'd2:            r = 6'd30;
            14'd3:            r = 6'd20;
            14'd4:            r = 6'd15;
            14'd5:            r = 6'd12;
            14'd6:            r = 6'd10;
            14'd7:            r = 6'd8;
            14'd8:            r = 6'd7;
            [14'd9:14'd10]:   r = 6'd6;
            [14'd11:14'd12]:  r = 6'd5;
            [14'd13:14'd15]:  r = 6'd4;
            [14'd16:14'd20]:  r = 6'd3;
            [14'd21:14'd30]:  r = 6'd2;
            [14'd31:14'd60]:  r = 6'd1;
            default:          r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

[hdl/pire_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pire_ram
// Generic single-write, single-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module pire_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/pire_rate_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pire_rate_unit
// Two-stage result path: span multiply, then rate lookup into the result
// register.
// ----------------------------------------------------------------------------
module pire_rate_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pire_pkg::rate_req_t           req,
    input  logic [pire_pkg::SPACING_W-1:0] spacing,
    output pire_pkg::result_t             result,
    output logic                          result_valid
);

    logic                        s1_vld_reg;
    logic                        s1_last_reg;
    logic [pire_pkg::SPAN_W-1:0] s1_span_reg;
    logic                        out_vld_reg;
    pire_pkg::result_t           out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= req.vld;
            out_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg <= req.last;
        s1_span_reg <= pire_pkg::SPAN_W'(req.gap) * pire_pkg::SPAN_W'(spacing);
        out_reg.span        <= s1_span_reg;
        out_reg.rate        <= pire_pkg::rate_of(s1_span_reg);
        out_reg.last_result <= s1_last_reg;
    end

    assign result       = out_reg;
    assign result_valid = out_vld_reg;

endmodule

[hdl/peak_interval_rate_estimator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_interval_rate_estimator
// Sample ring with peak search and per-peak interval rate results.
// ----------------------------------------------------------------------------
// A push word (command 0) writes one sample at the write position; busy
// stays low. An evaluate word (command 1) raises busy while the ring is
// read through the one read port of the sample RAM, one entry per cycle:
// a full pass of DEPTH reads finds the peak, the slot of its first
// occurrence and how often it occurs, then, if the peak occurs more than
// once, a second pass reads from the slot after the first peak up to the
// last peak slot. With a single peak busy drops after the first pass.
// Each result appears on result for one cycle with result_valid high,
// after its slot's read data has passed the span multiply and rate lookup
// registers of the rate unit, and the results of a run may still be
// leaving after busy falls. The receiver cannot stall the results, so it
// must take every strobed word. sample_spacing is written on the cfg
// channel (always ready) and must only change while the block is idle and
// all results have left. After reset the ring reads as all zero.
// ----------------------------------------------------------------------------
module peak_interval_rate_estimator #(
    parameter int DEPTH = pire_pkg::DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pire_pkg::cmd_t                 cmd,
    output pire_pkg::result_t              result,
    output logic                           result_valid,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pire_pkg::SPACING_W-1:0] cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // control
    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] iss_reg, iss_next;       // next slot to read
    logic          iss_on_reg, iss_on_next; // reads still to issue
    logic          pend_reg, pend_next;     // read data arrives this cycle
    logic [AW-1:0] rd_idx_reg, rd_idx_next; // slot of arriving data
    logic [AW-1:0] wpos_reg, wpos_next;
    logic [DEPTH-1:0] vbits_reg, vbits_next; // slot written since reset
    logic          vbit_rd_reg, vbit_rd_next;
    logic [pire_pkg::SPACING_W-1:0] spacing_reg;

    // scan results
    logic [pire_pkg::SAMPLE_W-1:0] peak_reg, peak_next;
    logic [AW-1:0] first_reg, first_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] emitted_reg, emitted_next;

    // RAM
    logic                          ram_we;
    logic                          ram_re;
    logic [pire_pkg::SAMPLE_W-1:0] ram_rdata;
    logic [pire_pkg::SAMPLE_W-1:0] rd_val;

    pire_pkg::rate_req_t req;
    logic                accept;
    logic                is_last;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign ram_we    = accept && (cmd.command == pire_pkg::CMD_PUSH);
    assign ram_re    = iss_on_reg;
    // never-written slots read as zero
    assign rd_val    = vbit_rd_reg ? ram_rdata : '0;
    assign is_last   = (emitted_reg + CW'(2)) == total_reg;

    pire_ram #(
        .WIDTH (pire_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wpos_reg),
        .wdata (cmd.sample),
        .re    (ram_re),
        .raddr (iss_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        iss_next     = iss_reg;
        iss_on_next  = iss_on_reg;
        pend_next    = 1'b0;
        rd_idx_next  = rd_idx_reg;
        wpos_next    = wpos_reg;
        vbits_next   = vbits_reg;
        vbit_rd_next = vbit_rd_reg;
        peak_next    = peak_reg;
        first_next   = first_reg;
        total_next   = total_reg;
        emitted_next = emitted_reg;
        req.vld      = 1'b0;
        req.gap      = pire_pkg::GAP_W'(rd_idx_reg - first_reg);
        req.last     = is_last;

        // read issue, shared by both passes
        if (iss_on_reg)
        begin
            pend_next    = 1'b1;
            rd_idx_next  = iss_reg;
            vbit_rd_next = vbits_reg[iss_reg];
            if (iss_reg == LAST_SLOT)
            begin
                iss_on_next = 1'b0;
            end
            else
            begin
                iss_next = iss_reg + AW'(1);
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.command == pire_pkg::CMD_PUSH)
                    begin
                        vbits_next[wpos_reg] = 1'b1;
                        wpos_next = (wpos_reg == LAST_SLOT) ? '0 : wpos_reg + AW'(1);
                    end
                    else
                    begin
                        state_next  = ST_SCAN;
                        iss_next    = '0;
                        iss_on_next = 1'b1;
                        peak_next   = '0;
                        first_next  = '0;
                        total_next  = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (pend_reg)
                begin
                    if (rd_val > peak_reg)
                    begin
                        peak_next  = rd_val;
                        first_next = rd_idx_reg;
                        total_next = CW'(1);
                    end
                    else if (rd_val == peak_reg)
                    begin
                        if (total_reg == '0)
                        begin
                            first_next = rd_idx_reg;
                        end
                        total_next = total_reg + CW'(1);
                    end
                    if (rd_idx_reg == LAST_SLOT)
                    begin
                        if (total_next < CW'(2))
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next   = ST_EMIT;
                            iss_next     = first_next + AW'(1);
                            iss_on_next  = 1'b1;
                            emitted_next = '0;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (pend_reg && (rd_val == peak_reg))
                begin
                    req.vld      = 1'b1;
                    emitted_next = emitted_reg + CW'(1);
                    if (is_last)
                    begin
                        state_next  = ST_IDLE;
                        iss_on_next = 1'b0;
                        pend_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next  = ST_IDLE;
                iss_on_next = 1'b0;
                pend_next   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            iss_reg     <= '0;
            iss_on_reg  <= 1'b0;
            pend_reg    <= 1'b0;
            rd_idx_reg  <= '0;
            wpos_reg    <= '0;
            vbits_reg   <= '0;
            vbit_rd_reg <= 1'b0;
            spacing_reg <= pire_pkg::SPACING_RESET;
            total_reg   <= '0;
            emitted_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            iss_reg     <= iss_next;
            iss_on_reg  <= iss_on_next;
            pend_reg    <= pend_next;
            rd_idx_reg  <= rd_idx_next;
            wpos_reg    <= wpos_next;
            vbits_reg   <= vbits_next;
            vbit_rd_reg <= vbit_rd_next;
            total_reg   <= total_next;
            emitted_reg <= emitted_next;
            if (cfg_valid && cfg_ready)
            begin
                spacing_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        peak_reg  <= peak_next;
        first_reg <= first_next;
    end

    pire_rate_unit u_rate (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .spacing      (spacing_reg),
        .result       (result),
        .result_valid (result_valid)
    );

`ifndef ASSERT_OFF
    a_push_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.command == pire_pkg::CMD_PUSH) |=> !busy)
        else $error("push left the block busy");

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.command == pire_pkg::CMD_EVAL) |=> busy)
        else $error("evaluate did not raise busy");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (emitted_reg + CW'(1) < total_reg))
        else $error("more results than peak repeats");

    a_zero_span_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.span == '0) == (result.rate == pire_pkg::RATE_SAT)))
        else $error("rate saturation does not match zero span");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE && !iss_on_reg))
        else $error("store written during a scan");
`endif

endmodule

[test/peak_interval_rate_estimator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_interval_rate_estimator_test
// Self-checking bench for the peak interval rate estimator: directed ring
// fills and spacing corners, then random push/evaluate phases checked word
// by word against a scoreboard that tracks the ring and the spacing.
// ----------------------------------------------------------------------------

class interval_rate_predictor;

    localparam int RING     = pire_pkg::DEPTH_DEFAULT;
    localparam int RATE_NUM = 60;

    logic [pire_pkg::SAMPLE_W-1:0]  ring [RING];
    int                             wr_slot;
    logic [pire_pkg::SPACING_W-1:0] spacing;
    pire_pkg::result_t              due_rates [$];
    int                             mismatches;

    function new();
        foreach (ring[i]) ring[i] = '0;
        wr_slot    = 0;
        spacing    = pire_pkg::SPACING_RESET;
        mismatches = 0;
    endfunction

    function void set_spacing(input logic [pire_pkg::SPACING_W-1:0] v);
        spacing = v;
    endfunction

    function int pending();
        return due_rates.size();
    endfunction

    // an accepted command word: push updates the ring, evaluate queues rates
    function void take_word(input pire_pkg::cmd_t w);
        logic [pire_pkg::SAMPLE_W-1:0] peak;
        int                            head;
        int                            hits;
        int                            seen;
        int                            span_full;
        pire_pkg::result_t             r;
        if (w.command == pire_pkg::CMD_PUSH) begin
            ring[wr_slot] = w.sample;
            wr_slot = (wr_slot == RING - 1) ? 0 : wr_slot + 1;
            return;
        end
        peak = '0;
        for (int i = 0; i < RING; i++)
            if (ring[i] > peak)
                peak = ring[i];
        hits = 0;
        head = 0;
        for (int i = 0; i < RING; i++) begin
            if (ring[i] == peak) begin
                if (hits == 0)
                    head = i;
                hits++;
            end
        end
        if (hits < 2)
            return;
        seen = 0;
        for (int i = head + 1; i < RING; i++) begin
            if (ring[i] == peak) begin
                seen++;
                span_full     = (i - head) * int'(spacing);
                r.span        = span_full[pire_pkg::SPAN_W-1:0];
                r.rate        = (span_full == 0) ? pire_pkg::RATE_SAT
                                                 : 6'(RATE_NUM / span_full);
                r.last_result = (seen == hits - 1);
                due_rates.push_back(r);
            end
        end
    endfunction

    function void check_rate(input pire_pkg::result_t got);
        pire_pkg::result_t want;
        if (due_rates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: span %0d rate %0d last %0d",
                         got.span, got.rate, got.last_result);
            return;
        end
        want = due_rates.pop_front();
        if (got.span !== want.span || got.rate !== want.rate ||
            got.last_result !== want.last_result) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected span %0d rate %0d last %0d, got span %0d rate %0d last %0d",
                         want.span, want.rate, want.last_result,
                         got.span, got.rate, got.last_result);
        end
    endfunction

endclass

module peak_interval_rate_estimator_test;

    import pire_pkg::*;

    // Watchdog limit with plenty of slack over the slowest honest run.
    localparam int LIMIT        = 400000;
    localparam int RANDOM_WORDS = 460;
    localparam int SETTLE       = 8;
    localparam logic [SAMPLE_W-1:0] TOP = '1;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    cmd_t                 cmd       = '0;
    result_t              result;
    logic                 result_valid;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [SPACING_W-1:0] cfg_data  = '0;

    interval_rate_predictor board = new();

    int  cycle_count = 0;
    bit  steady      = 1'b0;   // set during the no-idling stretch

    peak_interval_rate_estimator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result       (result),
        .result_valid (result_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Watchdog: a hang or a lost word ends up here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result words are strobed for one cycle and cannot be held off; sample
    // mid-cycle, away from the edge where they change.
    always @(negedge clk)
    begin
        if (rst_n && result_valid)
            board.check_rate(result);
    end

    // Offer one command word. Busy only moves at the rising edge, so its
    // value at the falling edge tells whether the next edge takes the word.
    task automatic send_word(input cmd_t w);
        if (!steady) begin
            while ($urandom_range(0, 99) < 36) begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        cmd   <= w;
        do @(negedge clk); while (busy);
        @(posedge clk);
        board.take_word(w);
    endtask

    task automatic push(input logic [SAMPLE_W-1:0] v);
        cmd_t w;
        w.command = CMD_PUSH;
        w.sample  = v;
        send_word(w);
    endtask

    task automatic evaluate();
        cmd_t w;
        w.command = CMD_EVAL;
        w.sample  = SAMPLE_W'($urandom());   // don't-care field, keep it moving
        send_word(w);
    endtask

    // Hold the sender back until every queued rate has arrived and the scan
    // has finished, then allow a settling margin for an evaluate with no output.
    task automatic wait_idle();
        start <= 1'b0;
        do @(negedge clk); while (board.pending() != 0 || busy);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_spacing(input logic [SPACING_W-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        board.set_spacing(v);
    endtask

    initial
    begin
        int                    sent;
        int                    phase_len;
        int                    kind;
        int                    pick;
        logic [SAMPLE_W-1:0]   peak;
        logic [SPACING_W-1:0]  gap;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Ring is all zero after reset: every slot is a peak, 63 words.
        evaluate();
        // Single peak gives nothing, second copy gives one word.
        push(TOP);
        evaluate();
        push(TOP);
        evaluate();
        push('0);
        push(TOP);
        evaluate();

        // Spacing corners on the same ring (peaks at slots 0, 1, 3).
        write_spacing(8'd1);
        evaluate();
        write_spacing(8'd255);
        evaluate();
        write_spacing(8'd0);     // zero span saturates the rate
        evaluate();
        write_spacing(8'd60);
        evaluate();
        push(10'h2AA);
        push(10'h155);
        evaluate();

        // Random phases: a fresh spacing each phase, then pushes mostly shaped
        // to give repeated peaks, evaluates mixed in, closed by an evaluate.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            pick = $urandom_range(0, 7);
            case (pick)
                0:       gap = 8'd0;
                1:       gap = 8'd1;
                2:       gap = 8'd255;
                default: gap = SPACING_W'($urandom());
            endcase
            write_spacing(gap);

            kind = $urandom_range(0, 5);
            peak = SAMPLE_W'($urandom());
            phase_len = (kind == 0) ? $urandom_range(66, 72) : $urandom_range(20, 60);

            for (int k = 0; k < phase_len; k++) begin
                steady = (sent >= 180 && sent < 280);
                pick   = $urandom_range(0, 99);
                if (k == phase_len - 1 || (kind != 0 && pick < 14)) begin
                    evaluate();
                end else if (kind == 0) begin
                    // constant fill: the whole ring ends up as peaks
                    push(peak);
                end else if (kind == 1) begin
                    push(SAMPLE_W'($urandom()));
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35)
                        push(peak);
                    else if (pick < 90)
                        push(peak == 0 ? '0 : SAMPLE_W'($urandom_range(0, peak - 1)));
                    else
                        push(SAMPLE_W'($urandom()));
                end
                sent++;
            end
        end
        steady = 1'b0;

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
